/* hdl/sfp_pkg.sv */
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the serial CAN line parser
// Holds the command passed from the byte classifier to the line engine,
// the decoded frame, and the fill-position codes of the digit store.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // digit store geometry and fill-position codes
  localparam int STORE_DEPTH  = 25;
  localparam int POS_COMPLETE = 25;
  localparam int POS_IDLE     = 26;
  localparam int MIN_DIGITS   = 9;
  localparam int MAX_DLC      = 8;
  localparam int DATA_BYTES   = 8;

  // depth of the command queue between classifier and line engine
  localparam int QUEUE_DEPTH  = 4;

  // classified poll
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,  // empty poll
    OP_START = 2'd1,  // line start character
    OP_END   = 2'd2,  // CR or LF
    OP_DIGIT = 2'd3   // any other byte, hex-decoded
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    logic [7:0]                 cmd;
    logic                       resp;
    logic [15:0]                hash;
    logic [3:0]                 dlc;
    logic [DATA_BYTES-1:0][7:0] data;
  } frame_t;

endpackage

/* hdl/sfp_front.sv */
// ----------------------------------------------------------------------------
// sfp_front: byte classifier
// Sorts each poll into start, line end, digit or empty poll and decodes
// the hex value of a digit byte (invalid characters decode to zero).
// ----------------------------------------------------------------------------
module sfp_front (
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  output sfp_pkg::cmd_t     cmd
);

  localparam logic [7:0] CHAR_START = 8'h54;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  logic [3:0] hex;

  // decode one ASCII hex digit
  always_comb begin
    hex = 4'd0;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hex = 4'(rx_byte - 8'h30);
    end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
      hex = 4'(rx_byte - 8'h41 + 8'd10);
    end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
      hex = 4'(rx_byte - 8'h61 + 8'd10);
    end
  end

  // classify the poll
  always_comb begin
    cmd.digit = hex;
    priority if (!byte_valid) begin
      cmd.op = sfp_pkg::OP_POLL;
    end else if (rx_byte == CHAR_START) begin
      cmd.op = sfp_pkg::OP_START;
    end else if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
      cmd.op = sfp_pkg::OP_END;
    end else begin
      cmd.op = sfp_pkg::OP_DIGIT;
    end
  end

endmodule

/* hdl/sfp_queue.sv */
// ----------------------------------------------------------------------------
// sfp_queue: command queue
// Short FIFO that decouples the classifier from the line engine so each
// side can stall on its own.
// ----------------------------------------------------------------------------
module sfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  sfp_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output sfp_pkg::cmd_t  rd_data
);

  localparam int DEPTH = sfp_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sfp_pkg::cmd_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // store an incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/sfp_back.sv */
// ----------------------------------------------------------------------------
// sfp_back: line engine
// Tracks the fill position, stores decoded digits and builds the frame
// into an output register once a good line is complete.
// ----------------------------------------------------------------------------
module sfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  sfp_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output sfp_pkg::frame_t  frame
);

  localparam logic [4:0] DEPTH    = 5'(sfp_pkg::STORE_DEPTH);
  localparam logic [4:0] COMPLETE = 5'(sfp_pkg::POS_COMPLETE);
  localparam logic [4:0] IDLE     = 5'(sfp_pkg::POS_IDLE);
  localparam logic [4:0] MIN_DIG  = 5'(sfp_pkg::MIN_DIGITS);
  localparam logic [3:0] MAX_LEN  = 4'(sfp_pkg::MAX_DLC);

  logic [4:0]      fill_position;
  logic [4:0]      fill_position_next;
  logic [3:0]      digit_store [sfp_pkg::STORE_DEPTH];
  logic            store_wr;
  logic            emit;
  logic            out_valid;
  logic            slot_free;
  logic [31:0]     id;
  logic [3:0]      len;
  sfp_pkg::frame_t frame_next;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign cmd_pop   = cmd_valid && slot_free;

  // next fill position and frame trigger
  always_comb begin
    fill_position_next = fill_position;
    store_wr           = 1'b0;
    emit               = 1'b0;
    if (cmd_pop) begin
      unique case (cmd.op)
        sfp_pkg::OP_START: begin
          fill_position_next = '0;
        end
        sfp_pkg::OP_END: begin
          if (fill_position < IDLE) begin
            fill_position_next = (fill_position >= MIN_DIG) ? COMPLETE : IDLE;
          end
        end
        sfp_pkg::OP_DIGIT: begin
          if (fill_position < DEPTH) begin
            store_wr           = 1'b1;
            fill_position_next = fill_position + 1'b1;
          end else if (fill_position == COMPLETE) begin
            emit               = 1'b1;
            fill_position_next = IDLE;
          end
        end
        sfp_pkg::OP_POLL: begin
          if (fill_position == COMPLETE) begin
            emit               = 1'b1;
            fill_position_next = IDLE;
          end
        end
        default: begin
          fill_position_next = fill_position;
        end
      endcase
    end
  end

  // build the frame from the stored digits
  always_comb begin
    id = {digit_store[0], digit_store[1], digit_store[2], digit_store[3],
          digit_store[4], digit_store[5], digit_store[6], digit_store[7]};
    len = (digit_store[8] > MAX_LEN) ? MAX_LEN : digit_store[8];
    frame_next.cmd  = id[24:17];
    frame_next.resp = id[16];
    frame_next.hash = id[15:0];
    frame_next.dlc  = len;
    for (int i = 0; i < sfp_pkg::DATA_BYTES; i++) begin
      if (4'(i) < len) begin
        frame_next.data[i] = {digit_store[9 + 2 * i], digit_store[10 + 2 * i]};
      end else begin
        frame_next.data[i] = 8'd0;
      end
    end
  end

  // hold fill position, digits and output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < sfp_pkg::STORE_DEPTH; i++) begin
        digit_store[i] <= 4'd0;
      end
    end else begin
      fill_position <= fill_position_next;
      if (store_wr) begin
        digit_store[fill_position] <= cmd.digit;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load the result beat
  always_ff @(posedge clk) begin
    if (emit) begin
      frame <= frame_next;
    end
  end

endmodule

/* hdl/slcan_frame_parser.sv */
// ----------------------------------------------------------------------------
// slcan_frame_parser: serial CAN text line parser for extended frames
// Turns polled UART bytes into decoded identifier, length and data fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive byte_valid/rx_byte and raise push; a beat is taken
//   at a clock edge with push high and full low. One beat per poll, with
//   byte_valid low for an empty poll.
//   Result channel: while empty is low the oldest frame sits on cmd, resp,
//   hash, dlc and data0..data7; raise pop to take it.
//   Throughput: one input beat per cycle while full is low. The classifier
//   feeds a 4-entry command queue; the line engine drains one command per
//   cycle from it while no frame waits or pop is high. A releasing poll
//   passes the queue register, then the line engine and the output register.
//   Stall: while a frame waits unpopped the line engine stops draining;
//   the queue takes up to 4 more beats before full rises.
//   Reset (rst, synchronous): queue and output empty, fill position zero,
//   digit store cleared. Ready for input as soon as reset is released.
// ----------------------------------------------------------------------------
module slcan_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cmd,
  output logic       resp,
  output logic [15:0] hash,
  output logic [3:0] dlc,
  output logic [7:0] data0,
  output logic [7:0] data1,
  output logic [7:0] data2,
  output logic [7:0] data3,
  output logic [7:0] data4,
  output logic [7:0] data5,
  output logic [7:0] data6,
  output logic [7:0] data7
);

  sfp_pkg::cmd_t   in_cmd;
  sfp_pkg::cmd_t   q_cmd;
  logic            q_valid;
  logic            q_pop;
  sfp_pkg::frame_t frame;

  // classify the incoming beat
  sfp_front u_front (
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .cmd        (in_cmd)
  );

  // decouple classifier and line engine
  sfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (in_cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  // run the line state and build frames
  sfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .frame     (frame)
  );

  assign cmd   = frame.cmd;
  assign resp  = frame.resp;
  assign hash  = frame.hash;
  assign dlc   = frame.dlc;
  assign data0 = frame.data[0];
  assign data1 = frame.data[1];
  assign data2 = frame.data[2];
  assign data3 = frame.data[3];
  assign data4 = frame.data[4];
  assign data5 = frame.data[5];
  assign data6 = frame.data[6];
  assign data7 = frame.data[7];

endmodule
